### hw/rtl/lfuc_pkg.sv
`timescale 1ns / 1ps

package lfuc_pkg;

    // Default geometry
    localparam int CAPACITY_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    // Capacity register after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Action codes carried in the input tuser
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLAN,
        ST_SWEEP,
        ST_COMMIT,
        ST_DONE
    } t_state;

    // Table update kind chosen after the scan
    typedef enum logic [1:0] {
        OP_NONE,
        OP_BUMP,
        OP_INSERT
    } t_op;

endpackage

### hw/rtl/lfu_cache_lookup_evict_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_tvalid / o_s_tready    tuser: action; tdata: key, value
// m_axis    out  o_m_tvalid / i_m_tready    tuser: hit, evicted; tdata: read_value, evicted_key
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data: capacity_in_use
//
// Words are taken one at a time. A scan pass reads one table slot per cycle to find
// the key, the victim and the first free slot, then a second pass rewrites the recency
// ranks one slot per cycle through the rank table. Gets that miss and puts with
// capacity zero skip the second pass.
// Reset is synchronous, active low; it clears all valid bits and the fill count.
// A result waits in the output register while the next word is accepted; the block
// stalls only when a new result is ready and the previous one is still not taken.
module lfu_cache_lookup_evict_core #(
    parameter int CAPACITY   = lfuc_pkg::CAPACITY_DEF,
    parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input words
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [63:0]               i_s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]                i_s_tuser,   // [0] action
    // result words
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [63:0]               o_m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]                o_m_tuser,   // [0] hit, [1] evicted
    // capacity register
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lfuc_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CMPW = (CNTW > lfuc_pkg::CFG_W) ? CNTW : lfuc_pkg::CFG_W;
    localparam int KW   = lfuc_pkg::KEY_W;
    localparam int DW   = lfuc_pkg::DATA_W;

    // control state
    lfuc_pkg::t_state        r_state, n_state;
    logic [CNTW-1:0]         r_addr;
    logic                    r_rd_vld;
    logic [AW-1:0]           r_rd_idx;
    logic [lfuc_pkg::CFG_W-1:0] r_cap_cfg;
    logic [CAPACITY-1:0]     r_valid;
    logic [CAPACITY-1:0]     n_valid;
    logic [CNTW-1:0]         r_used;
    logic                    r_out_valid;

    // current word
    logic                    r_act;
    logic [KW-1:0]           r_key;
    logic [DW-1:0]           r_val;

    // scan results
    logic                    r_found;
    logic [AW-1:0]           r_s_idx;
    logic [AW-1:0]           r_s_rank;
    logic [COUNT_BITS-1:0]   r_s_cnt;
    logic [DW-1:0]           r_s_data;
    logic                    r_free_found;
    logic [AW-1:0]           r_free_idx;
    logic                    r_vic_found;
    logic [AW-1:0]           r_vic_idx;
    logic [COUNT_BITS-1:0]   r_vic_cnt;
    logic [AW-1:0]           r_vic_rank;
    logic [KW-1:0]           r_vic_key;

    // plan
    lfuc_pkg::t_op           r_op;
    logic                    r_evict;
    logic [AW-1:0]           r_slot;

    // result register
    logic                    r_res_hit;
    logic [DW-1:0]           r_res_rd;
    logic                    r_res_ev;
    logic [KW-1:0]           r_res_evk;

    // table read data
    logic [KW-1:0]           key_q;
    logic [DW-1:0]           data_q;
    logic [COUNT_BITS-1:0]   cnt_q;
    logic [AW-1:0]           rank_q;

    logic                    accept;
    logic                    issue;
    logic                    last_rd;
    logic                    load_out;
    logic                    slot_valid;
    logic                    take_vic;

    logic [CMPW-1:0]         cap_eff;
    logic [CMPW-1:0]         used_ext;
    lfuc_pkg::t_op           plan_op;
    logic                    plan_evict;
    logic [AW-1:0]           plan_slot;

    logic                    rank_we;
    logic [AW-1:0]           rank_new;
    logic                    cnt_we;
    logic [COUNT_BITS-1:0]   cnt_new;
    logic                    data_we;
    logic                    key_we;

    assign o_s_tready  = (r_state == lfuc_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && o_s_tready;

    // Sequencer: next state and pass control
    always_comb begin
        n_state  = r_state;
        issue    = ((r_state == lfuc_pkg::ST_SCAN) || (r_state == lfuc_pkg::ST_SWEEP)) &&
                   (r_addr < CNTW'(CAPACITY));
        last_rd  = r_rd_vld && (r_rd_idx == AW'(CAPACITY - 1));
        load_out = 1'b0;
        case (r_state)
            lfuc_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = lfuc_pkg::ST_SCAN;
            end
            lfuc_pkg::ST_SCAN: begin
                if (last_rd) n_state = lfuc_pkg::ST_PLAN;
            end
            lfuc_pkg::ST_PLAN: begin
                n_state = (plan_op == lfuc_pkg::OP_NONE) ? lfuc_pkg::ST_DONE
                                                         : lfuc_pkg::ST_SWEEP;
            end
            lfuc_pkg::ST_SWEEP: begin
                if (last_rd) n_state = lfuc_pkg::ST_COMMIT;
            end
            lfuc_pkg::ST_COMMIT: begin
                n_state = lfuc_pkg::ST_DONE;
            end
            lfuc_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = lfuc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfuc_pkg::ST_IDLE;
            end
        endcase
    end

    // Compare unit of the scan pass
    always_comb begin
        slot_valid = r_valid[r_rd_idx];
        take_vic   = slot_valid &&
                     (!r_vic_found || (cnt_q < r_vic_cnt) ||
                      ((cnt_q == r_vic_cnt) && (rank_q > r_vic_rank)));
    end

    // Decide the table update from the scan results
    always_comb begin
        cap_eff    = (CMPW'(r_cap_cfg) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY)
                                                         : CMPW'(r_cap_cfg);
        used_ext   = CMPW'(r_used);
        plan_op    = lfuc_pkg::OP_NONE;
        plan_evict = 1'b0;
        plan_slot  = r_s_idx;
        if (r_act == lfuc_pkg::ACT_GET) begin
            if (r_found) plan_op = lfuc_pkg::OP_BUMP;
        end else if (cap_eff != '0) begin
            if (r_found) begin
                plan_op = lfuc_pkg::OP_BUMP;
            end else begin
                plan_evict = (used_ext >= cap_eff) && r_vic_found;
                if (plan_evict) begin
                    plan_op   = lfuc_pkg::OP_INSERT;
                    plan_slot = (r_free_found && (r_free_idx < r_vic_idx)) ? r_free_idx
                                                                           : r_vic_idx;
                end else if (r_free_found) begin
                    plan_op   = lfuc_pkg::OP_INSERT;
                    plan_slot = r_free_idx;
                end
            end
        end
    end

    // Rank rewrite of the sweep pass
    always_comb begin
        rank_we  = 1'b0;
        rank_new = rank_q;
        if ((r_state == lfuc_pkg::ST_SWEEP) && r_rd_vld) begin
            if (r_rd_idx == r_slot) begin
                rank_we  = 1'b1;
                rank_new = '0;
            end else if (r_op == lfuc_pkg::OP_BUMP) begin
                if (slot_valid && (rank_q < r_s_rank)) begin
                    rank_we  = 1'b1;
                    rank_new = rank_q + AW'(1);
                end
            end else if (slot_valid && !(r_evict && (r_rd_idx == r_vic_idx))) begin
                // close the victim's gap, then age for the new entry
                rank_we  = 1'b1;
                rank_new = (r_evict && (rank_q > r_vic_rank)) ? rank_q : rank_q + AW'(1);
            end
        end
    end

    // Final slot writes
    always_comb begin
        cnt_we  = (r_state == lfuc_pkg::ST_COMMIT) && (r_op != lfuc_pkg::OP_NONE);
        data_we = cnt_we && (r_act == lfuc_pkg::ACT_PUT);
        key_we  = cnt_we && (r_op == lfuc_pkg::OP_INSERT);
        if (r_op == lfuc_pkg::OP_BUMP) begin
            cnt_new = (r_s_cnt == '1) ? r_s_cnt : r_s_cnt + COUNT_BITS'(1);
        end else begin
            cnt_new = COUNT_BITS'(1);
        end
    end

    // Valid bits: free the victim, then claim the new slot
    always_comb begin
        n_valid = r_valid;
        if ((r_state == lfuc_pkg::ST_COMMIT) && (r_op == lfuc_pkg::OP_INSERT)) begin
            if (r_evict) begin
                n_valid[r_vic_idx] = 1'b0;
            end
            n_valid[r_slot] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfuc_pkg::ST_IDLE;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_cap_cfg   <= lfuc_pkg::CFG_RESET;
            r_valid     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (accept || (r_state == lfuc_pkg::ST_PLAN)) begin
                r_addr <= '0;
            end else if (issue) begin
                r_addr <= r_addr + CNTW'(1);
            end
            if (i_cfg_valid) begin
                r_cap_cfg <= i_cfg_data;
            end
            r_valid <= n_valid;
            // an eviction keeps the fill count, a plain insert grows it
            if ((r_state == lfuc_pkg::ST_COMMIT) && (r_op == lfuc_pkg::OP_INSERT) &&
                !r_evict) begin
                r_used <= r_used + CNTW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[AW-1:0];
        if (accept) begin
            r_act        <= i_s_tuser[0];
            r_key        <= i_s_tdata[31:0];
            r_val        <= i_s_tdata[63:32];
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end
        // scan: track match, first free slot and victim
        if ((r_state == lfuc_pkg::ST_SCAN) && r_rd_vld) begin
            if (slot_valid && (key_q == r_key) && !r_found) begin
                r_found  <= 1'b1;
                r_s_idx  <= r_rd_idx;
                r_s_rank <= rank_q;
                r_s_cnt  <= cnt_q;
                r_s_data <= data_q;
            end
            if (!slot_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (take_vic) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_rd_idx;
                r_vic_cnt   <= cnt_q;
                r_vic_rank  <= rank_q;
                r_vic_key   <= key_q;
            end
        end
        // plan: latch the update
        if (r_state == lfuc_pkg::ST_PLAN) begin
            r_op    <= plan_op;
            r_evict <= plan_evict;
            r_slot  <= plan_slot;
        end
        // load the result only once the output register is free
        if (load_out) begin
            r_res_hit <= r_found;
            r_res_rd  <= ((r_act == lfuc_pkg::ACT_GET) && r_found) ? r_s_data : '1;
            r_res_ev  <= r_evict;
            r_res_evk <= r_evict ? r_vic_key : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_res_evk, r_res_rd};
    assign o_m_tuser  = {r_res_ev, r_res_hit};

    // Slot tables
    lfuc_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_slot),
        .i_wdata (r_key),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (key_q)
    );

    lfuc_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata (r_val),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (data_q)
    );

    lfuc_ram #(.WIDTH(COUNT_BITS), .DEPTH(CAPACITY)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_slot),
        .i_wdata (cnt_new),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (cnt_q)
    );

    lfuc_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_rd_idx),
        .i_wdata (rank_new),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rank_q)
    );

    // Fill count tracks the valid bits
    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("fill count differs from number of valid slots");

    // An accepted word starts a scan
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == lfuc_pkg::ST_SCAN))
        else $error("accepted word did not start a scan");

    // An insert lands on a free slot or on the slot it evicts
    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lfuc_pkg::ST_COMMIT) && (r_op == lfuc_pkg::OP_INSERT)) |->
        (!r_valid[r_slot] || (r_evict && (r_slot == r_vic_idx))))
        else $error("insert overwrites a live slot");

    // A new result only comes out of the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == lfuc_pkg::ST_DONE))
        else $error("result raised outside the done state");

endmodule

### hw/rtl/lfuc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port table: one write, one registered read per cycle
module lfuc_ram #(
    parameter int WIDTH = lfuc_pkg::DATA_W,
    parameter int DEPTH = lfuc_pkg::CAPACITY_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
